### hw/rtl/scrb_pkg.sv
// Shared types, widths, constants and saturation helper for the comb resonator bank.
package scrb_pkg;

  localparam int SMP_W      = 16;     // audio field width at the ports
  localparam int DATA_W     = 24;     // delay store word width
  localparam int WRAP_W     = 13;     // wrap field width in a voice setup word
  localparam int COEF_W     = 12;     // feedback and gain width, Q0.12
  localparam int ACC_W      = 42;     // voice sum accumulator, covers up to 16 voices
  localparam int SETUP_W    = 62;
  localparam int LEVEL_W    = 13;     // mix level and output scale
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 62;
  localparam int ONE_Q12    = 4096;
  localparam int DCB_COEF   = 32604;  // 0.995 in Q1.15
  localparam int MIX_RESET  = 2048;
  localparam int SCALE_RESET = 4096;

  typedef struct packed {
    logic start;  // new request accepted: clear sums and store base
    logic issue;  // one voice slot this cycle
  } lane_ctl_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_VOICE = 5'b00100,
    S_MERGE = 5'b01000,
    S_OUT   = 5'b10000
  } core_state_e;

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) begin
      return 24'h7FFFFF;
    end else if (v < -48'sd8388608) begin
      return 24'h800000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

### hw/rtl/scrb_if.sv
// Handshake interfaces for the sample input, sample output and register write channels.
interface scrb_in_if;
  import scrb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_in;
  logic signed [SMP_W-1:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scrb_out_if;
  import scrb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_out;
  logic signed [SMP_W-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface scrb_cfg_if;
  import scrb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/scrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module scrb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/scrb_lane.sv
// One channel lane: per-voice heads, delay memory, comb update pipeline and gain sum.
module scrb_lane #(
  parameter int MAX_DELAY = 8192,
  parameter int VOICES    = 6
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  scrb_pkg::lane_ctl_t                           ctl_i,
  input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice_i,
  input  logic [scrb_pkg::WRAP_W-1:0]                   wrap_i,
  input  logic [scrb_pkg::COEF_W-1:0]                   fb_i,
  input  logic [scrb_pkg::COEF_W-1:0]                   gain_i,
  input  logic signed [scrb_pkg::SMP_W-1:0]             sample_i,
  output logic signed [scrb_pkg::ACC_W-1:0]             sum_o,
  output logic                                          ready_o
);
  import scrb_pkg::*;

  localparam int HEAD_W = $clog2(MAX_DELAY);
  localparam int DEPTH  = VOICES * MAX_DELAY;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = ((HEAD_W > WRAP_W) ? HEAD_W : WRAP_W) + 1;
  localparam int PROD_W = COEF_W + 1 + DATA_W;

  logic [HEAD_W-1:0] heads_q [VOICES];
  logic [ADDR_W-1:0] base_q;
  logic              clearing_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic              issue_act;
  logic [HEAD_W-1:0] head, head_next;
  logic [CMP_W-1:0]  wrap_ext, wrap_c, head_inc;
  logic [ADDR_W-1:0] rd_addr;

  logic                     vb_q, vc_q;
  logic [ADDR_W-1:0]        addr_b_q, addr_c_q;
  logic [COEF_W-1:0]        fb_b_q, gain_b_q;
  logic signed [PROD_W-1:0] pfb_d, pg_d, pfb_c_q, pg_c_q;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] rd;
  logic signed [25:0]       fb_term;
  logic signed [47:0]       wsum;
  logic signed [DATA_W-1:0] wdata;
  logic signed [ACC_W-1:0]  acc_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  // Frozen voices take their slot but touch nothing.
  assign issue_act = ctl_i.issue && (gain_i != '0);
  assign head      = heads_q[voice_i];
  assign wrap_ext  = CMP_W'(wrap_i);
  assign wrap_c    = (wrap_ext > CMP_W'(MAX_DELAY - 1)) ? CMP_W'(MAX_DELAY - 1) : wrap_ext;
  assign head_inc  = CMP_W'(head) + 1'b1;
  assign head_next = (head_inc > wrap_c) ? '0 : head_inc[HEAD_W-1:0];
  assign rd_addr   = base_q + ADDR_W'(head);

  assign rd    = $signed(rdata);
  assign pfb_d = $signed({1'b0, fb_b_q}) * rd;
  assign pg_d  = $signed({1'b0, gain_b_q}) * rd;

  assign fb_term = 26'((pfb_c_q + 37'sd2048) >>> 12);
  assign wsum    = 48'(fb_term) + 48'(sample_i);
  assign wdata   = sat24(wsum);

  // Clear sweep owns the write port until the whole store is zero.
  assign ram_we    = clearing_q || vc_q;
  assign ram_waddr = clearing_q ? clr_addr_q : addr_c_q;
  assign ram_wdata = clearing_q ? '0 : wdata;

  scrb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        heads_q[v] <= '0;
      end
      base_q <= '0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      acc_q  <= '0;
    end else begin
      vb_q <= issue_act;
      vc_q <= vb_q;
      if (ctl_i.start) begin
        base_q <= '0;
        acc_q  <= '0;
      end else begin
        if (ctl_i.issue) begin
          base_q <= base_q + ADDR_W'(MAX_DELAY);
        end
        if (vc_q) begin
          acc_q <= acc_q + ACC_W'(pg_c_q);
        end
      end
      if (issue_act) begin
        heads_q[voice_i] <= head_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_b_q <= rd_addr;
    fb_b_q   <= fb_i;
    gain_b_q <= gain_i;
    addr_c_q <= addr_b_q;
    pfb_c_q  <= pfb_d;
    pg_c_q   <= pg_d;
  end

  assign sum_o   = acc_q;
  assign ready_o = !clearing_q;

endmodule

### hw/rtl/scrb_merge.sv
// Merge stage: rounds both lane sums, DC-blocks, scales, saturates and crossfades with dry.
module scrb_merge #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [scrb_pkg::ACC_W-1:0]  sum_i [2],
  input  logic signed [scrb_pkg::SMP_W-1:0]  dry_i [2],
  input  logic [scrb_pkg::LEVEL_W-1:0]       mix_i,
  input  logic [scrb_pkg::LEVEL_W-1:0]       scale_i,
  output logic signed [scrb_pkg::SMP_W-1:0]  out_o [2],
  output logic                               done_o
);
  import scrb_pkg::*;

  localparam logic signed [37:0] W_HI = 38'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [37:0] W_LO = -W_HI - 38'sd1;

  logic [5:0] st_q;

  logic signed [DATA_W-1:0] pin_q [2];
  logic signed [DATA_W-1:0] pout_q [2];
  logic signed [DATA_W-1:0] x_q [2], x_d [2];
  logic signed [40:0]       pdc_q [2], pdc_d [2];
  logic signed [DATA_W-1:0] y_q [2], y_d [2];
  logic signed [37:0]       pw_q [2], pw_d [2], pw_rnd [2];
  logic signed [25:0]       w_q [2], w_d [2];
  logic signed [26:0]       diff [2];
  logic signed [40:0]       pm_q [2], pm_d [2];
  logic signed [SMP_W-1:0]  o_q [2], o_d [2];

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      x_d[ch]    = sat24(48'((sum_i[ch] + 42'sd2048) >>> 12));
      pdc_d[ch]  = 41'(pout_q[ch]) * 41'(DCB_COEF);
      y_d[ch]    = sat24(48'(x_q[ch]) - 48'(pin_q[ch]) +
                         48'((pdc_q[ch] + 41'sd16384) >>> 15));
      pw_d[ch]   = 38'(y_q[ch]) * 38'($signed({1'b0, scale_i}));
      pw_rnd[ch] = (pw_q[ch] + 38'sd2048) >>> 12;
      if (pw_rnd[ch] > W_HI) begin
        w_d[ch] = 26'(W_HI);
      end else if (pw_rnd[ch] < W_LO) begin
        w_d[ch] = 26'(W_LO);
      end else begin
        w_d[ch] = pw_rnd[ch][25:0];
      end
      diff[ch] = 27'(w_q[ch]) - 27'(dry_i[ch]);
      pm_d[ch] = 41'(diff[ch]) * 41'($signed({1'b0, mix_i}));
      o_d[ch]  = SMP_W'(48'(dry_i[ch]) + 48'((pm_q[ch] + 41'sd2048) >>> 12));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      for (int ch = 0; ch < 2; ch++) begin
        pin_q[ch]  <= '0;
        pout_q[ch] <= '0;
      end
    end else begin
      st_q <= {st_q[4:0], start_i};
      if (st_q[0]) begin
        for (int ch = 0; ch < 2; ch++) begin
          pin_q[ch]  <= x_q[ch];
          pout_q[ch] <= y_d[ch];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 2; ch++) begin
      if (start_i) begin
        x_q[ch]   <= x_d[ch];
        pdc_q[ch] <= pdc_d[ch];
      end
      if (st_q[0]) y_q[ch]  <= y_d[ch];
      if (st_q[1]) pw_q[ch] <= pw_d[ch];
      if (st_q[2]) w_q[ch]  <= w_d[ch];
      if (st_q[3]) pm_q[ch] <= pm_d[ch];
      if (st_q[4]) o_q[ch]  <= o_d[ch];
    end
  end

  assign out_o  = o_q;
  assign done_o = st_q[5];

endmodule

### hw/rtl/stereo_comb_resonator_bank_core.sv
// Stereo feedback comb resonator bank: one lane per channel walks the voices, a merge
// stage DC-blocks, scales and crossfades. After reset both delay memories are swept to
// zero, one word per cycle across all VOICES * MAX_DELAY words; no request is taken
// during the sweep, register writes are. For each request, each lane issues one voice
// per cycle into its delay memory (read, multiply, write back over three stages), and
// the six-stage merge pipeline follows. The next request is accepted as soon as the
// result has moved into the output register, which holds it until taken.
module stereo_comb_resonator_bank_core #(
  parameter int MAX_DELAY   = 8192,
  parameter int VOICES      = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scrb_in_if.sink    in_i,
  scrb_out_if.source out_o,
  scrb_cfg_if.sink   cfg_i
);
  import scrb_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W  = $clog2(VOICES + 3);
  localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(VOICES + 2);
  localparam logic [CFG_IDX_W-1:0] IDX_MIX   = CFG_IDX_W'(VOICES);
  localparam logic [CFG_IDX_W-1:0] IDX_SCALE = CFG_IDX_W'(VOICES + 1);

  core_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [SETUP_W-1:0] setup_q [VOICES];
  logic [LEVEL_W-1:0] mix_q, scale_q, mix_c, scale_c;

  logic signed [SMP_W-1:0] dry_q [2];
  logic signed [ACC_W-1:0] sum_w [2];
  logic signed [SMP_W-1:0] mix_out [2];
  logic                    ready_l, ready_r, lanes_ready;

  lane_ctl_t          lctl;
  logic [VIDX_W-1:0]  vidx;
  logic [SETUP_W-1:0] sel;

  logic in_acc, cfg_acc, merge_start, merge_done, out_free, load_out;
  logic out_valid_q;
  logic signed [SMP_W-1:0] out_left_q, out_right_q;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        setup_q[v] <= '0;
      end
      mix_q   <= LEVEL_W'(MIX_RESET);
      scale_q <= LEVEL_W'(SCALE_RESET);
    end else if (cfg_acc) begin
      if (cfg_i.index < IDX_MIX) begin
        setup_q[cfg_i.index[VIDX_W-1:0]] <= cfg_i.data[SETUP_W-1:0];
      end else if (cfg_i.index == IDX_MIX) begin
        mix_q <= cfg_i.data[LEVEL_W-1:0];
      end else if (cfg_i.index == IDX_SCALE) begin
        scale_q <= cfg_i.data[LEVEL_W-1:0];
      end
    end
  end

  assign mix_c   = (mix_q > LEVEL_W'(ONE_Q12)) ? LEVEL_W'(ONE_Q12) : mix_q;
  assign scale_c = (scale_q > LEVEL_W'(ONE_Q12)) ? LEVEL_W'(ONE_Q12) : scale_q;

  // Sequencer.
  assign lanes_ready = ready_l && ready_r;
  assign lctl.start  = in_acc;
  assign lctl.issue  = (state_q == S_VOICE) && (cnt_q < CNT_W'(VOICES));
  assign vidx        = lctl.issue ? cnt_q[VIDX_W-1:0] : '0;
  assign sel         = setup_q[vidx];
  assign merge_start = (state_q == S_VOICE) && (cnt_q == CNT_LAST);
  assign out_free    = !out_valid_q || out_o.ready;
  assign load_out    = out_free &&
                       (((state_q == S_MERGE) && merge_done) || (state_q == S_OUT));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_CLEAR: begin
        if (lanes_ready) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_VOICE;
          cnt_d   = '0;
        end
      end
      S_VOICE: begin
        if (cnt_q == CNT_LAST) begin
          state_d = S_MERGE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MERGE: begin
        if (merge_done) state_d = out_free ? S_IDLE : S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dry_q[0] <= in_i.left_in;
      dry_q[1] <= in_i.right_in;
    end
  end

  scrb_lane #(
    .MAX_DELAY(MAX_DELAY),
    .VOICES   (VOICES)
  ) u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lctl),
    .voice_i  (vidx),
    .wrap_i   (sel[12:0]),
    .fb_i     (sel[37:26]),
    .gain_i   (sel[61:50]),
    .sample_i (dry_q[0]),
    .sum_o    (sum_w[0]),
    .ready_o  (ready_l)
  );

  scrb_lane #(
    .MAX_DELAY(MAX_DELAY),
    .VOICES   (VOICES)
  ) u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lctl),
    .voice_i  (vidx),
    .wrap_i   (sel[25:13]),
    .fb_i     (sel[49:38]),
    .gain_i   (sel[61:50]),
    .sample_i (dry_q[1]),
    .sum_o    (sum_w[1]),
    .ready_o  (ready_r)
  );

  scrb_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (merge_start),
    .sum_i   (sum_w),
    .dry_i   (dry_q),
    .mix_i   (mix_c),
    .scale_i (scale_c),
    .out_o   (mix_out),
    .done_o  (merge_done)
  );

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_left_q  <= mix_out[0];
      out_right_q <= mix_out[1];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_left_q;
  assign out_o.right_out = out_right_q;

`ifndef SYNTHESIS
  a_merge_done_in_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_done |-> (state_q == S_MERGE))
    else $error("merge result arrived outside the merge phase");

  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((state_q == S_VOICE) && (cnt_q == '0)))
    else $error("accepted request did not start the voice walk");

  a_load_shows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

### tb/sv/stereo_comb_resonator_bank_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stereo comb resonator bank core.
module stereo_comb_resonator_bank_core_tb;
  import scrb_pkg::*;

  localparam int MAX_DELAY       = 8192;
  localparam int VOICES          = 6;
  localparam int SAMPLE_BITS     = 16;
  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 11;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_CYCLES     = 600;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 250000;
  localparam int MAX_REPORTS     = 10;
  localparam int DCB_SHIFT       = 15;
  localparam int COEF_MAX        = (1 << COEF_W) - 1;
  localparam int WRAP_MAX        = (1 << WRAP_W) - 1;
  localparam int LEVEL_MAX       = (1 << LEVEL_W) - 1;
  localparam int SMP_MAX         = (1 << (SMP_W - 1)) - 1;
  localparam int SMP_MIN         = -(1 << (SMP_W - 1));

  localparam logic [CFG_IDX_W-1:0] REG_VOICE1     = 0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX        = REG_VOICE1 + VOICES;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = REG_MIX + 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = REG_SCALE + 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic signed [SMP_W-1:0] left;
    logic signed [SMP_W-1:0] right;
  } stereo_t;

  class comb_bank_scoreboard;
    bit signed [DATA_W-1:0] store [2][VOICES*MAX_DELAY];
    int                     head [2][VOICES];
    longint                 dc_in [2];
    longint                 dc_out [2];
    logic [SETUP_W-1:0]     setup [VOICES];
    logic [LEVEL_W-1:0]     mix_level;
    logic [LEVEL_W-1:0]     out_scale;
    stereo_t                samples_due [$];
    int                     mismatches;

    function new();
      foreach (setup[v]) setup[v] = '0;
      mix_level  = MIX_RESET;
      out_scale  = SCALE_RESET;
      mismatches = 0;
    endfunction

    // Divide by 2^sh, round half toward plus infinity.
    function longint round_q(longint x, int sh);
      return (x + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < REG_MIX) setup[idx] = data[SETUP_W-1:0];
      else if (idx == REG_MIX) mix_level = data[LEVEL_W-1:0];
      else if (idx == REG_SCALE) out_scale = data[LEVEL_W-1:0];
    endfunction

    // One comb voice on one channel: read at the head, write back, advance.
    function longint resonate(int ch, int v, int wrap, longint fb, longint x);
      int     h;
      int     addr;
      longint rd;
      h = head[ch][v];
      if (h >= MAX_DELAY) h = 0;
      if (wrap > MAX_DELAY - 1) wrap = MAX_DELAY - 1;
      addr = v * MAX_DELAY + h;
      rd = store[ch][addr];
      store[ch][addr] = DATA_W'(clip(x + round_q(fb * rd, COEF_W), DATA_W));
      h++;
      if (h > wrap) h = 0;
      head[ch][v] = h;
      return rd;
    endfunction

    function void note_sample(logic signed [SMP_W-1:0] l, logic signed [SMP_W-1:0] r);
      longint  dry [2];
      longint  acc [2];
      longint  gain, fb, x, y, w, o, lvl, scl;
      int      wrap;
      stereo_t want;
      dry[0] = l;
      dry[1] = r;
      acc[0] = 0;
      acc[1] = 0;
      lvl = (mix_level > ONE_Q12) ? ONE_Q12 : mix_level;
      scl = (out_scale > ONE_Q12) ? ONE_Q12 : out_scale;
      for (int v = 0; v < VOICES; v++) begin
        gain = setup[v][SETUP_W-1 -: COEF_W];
        // zero gain freezes the voice entirely
        if (gain == 0) continue;
        for (int ch = 0; ch < 2; ch++) begin
          wrap = setup[v][ch*WRAP_W +: WRAP_W];
          fb   = setup[v][2*WRAP_W + ch*COEF_W +: COEF_W];
          acc[ch] += gain * resonate(ch, v, wrap, fb, dry[ch]);
        end
      end
      for (int ch = 0; ch < 2; ch++) begin
        x = clip(round_q(acc[ch], COEF_W), DATA_W);
        y = clip(x - dc_in[ch] + round_q(longint'(DCB_COEF) * dc_out[ch], DCB_SHIFT), DATA_W);
        dc_in[ch]  = x;
        dc_out[ch] = y;
        w = clip(round_q(y * scl, COEF_W), SAMPLE_BITS);
        o = dry[ch] + round_q((w - dry[ch]) * lvl, COEF_W);
        if (ch == 0) want.left = o[SMP_W-1:0];
        else want.right = o[SMP_W-1:0];
      end
      samples_due.push_back(want);
    endfunction

    function void check_output(logic signed [SMP_W-1:0] l, logic signed [SMP_W-1:0] r);
      stereo_t want;
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unrequested sample left %0d right %0d", $time, l, r);
        return;
      end
      want = samples_due.pop_front();
      if (want.left !== l || want.right !== r) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: sample mismatch: left want %0d got %0d, right want %0d got %0d",
                   $time, want.left, l, want.right, r);
      end
    endfunction

    function int outstanding();
      return samples_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_out_req;
  int   quiet_cycles;

  comb_bank_scoreboard sb = new();

  scrb_in_if  in_if ();
  scrb_out_if out_if ();
  scrb_cfg_if cfg_if ();

  stereo_comb_resonator_bank_core #(
    .MAX_DELAY  (MAX_DELAY),
    .VOICES     (VOICES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic logic [SETUP_W-1:0] pack_voice(int wl, int wr, int fbl, int fbr, int gain);
    return {gain[COEF_W-1:0], fbr[COEF_W-1:0], fbl[COEF_W-1:0], wr[WRAP_W-1:0], wl[WRAP_W-1:0]};
  endfunction

  function automatic int rand_wrap();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, WRAP_MAX) : $urandom_range(0, 40);
  endfunction

  function automatic int rand_fb();
    return ($urandom_range(0, 7) == 0) ? COEF_MAX : $urandom_range(0, COEF_MAX);
  endfunction

  function automatic logic [SETUP_W-1:0] rand_voice();
    int gain;
    case ($urandom_range(0, 9))
      0: return SETUP_W'({$urandom, $urandom});
      1, 2: gain = 0;
      3: gain = COEF_MAX;
      default: gain = $urandom_range(1, COEF_MAX);
    endcase
    return pack_voice(rand_wrap(), rand_wrap(), rand_fb(), rand_fb(), gain);
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ONE_Q12;
      2: return LEVEL_MAX;
      3: return $urandom_range(ONE_Q12 + 1, LEVEL_MAX);
      default: return $urandom_range(0, ONE_Q12);
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2, 3: return $urandom_range(0, 511) - 256;
      default: return $urandom;
    endcase
  endfunction

  // Entered at a falling edge; returns at a falling edge with valid left high.
  task automatic send_sample(input logic signed [SMP_W-1:0] l, input logic signed [SMP_W-1:0] r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.left_in  <= l;
    in_if.right_in <= r;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_sample(l, r);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop offering and hold until every pending result has been taken.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure_random();
    for (int v = 0; v < VOICES; v++) write_reg(REG_VOICE1 + v, rand_voice());
    write_reg(REG_MIX, rand_level());
    write_reg(REG_SCALE, rand_level());
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(REG_SPARE_LO, REG_SPARE_HI), {$urandom, $urandom});
  endtask

  // Receiver: random stalls, plus one long hold-off whenever requested.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_output(out_if.left_out, out_if.right_out);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid    = 1'b0;
    in_if.left_in  = '0;
    in_if.right_in = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    hold_out_req   = 1'b0;
    quiet_cycles   = 0;
    src_idle_pct   = 11;
    snk_idle_pct   = 83;
    rst_ni         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: every voice frozen.
    send_sample(SMP_MAX, SMP_MIN);
    send_sample(SMP_MIN, SMP_MAX);
    drain();

    // Short loops, full feedback, frozen voices, spare indexes.
    write_reg(REG_VOICE1,     pack_voice(3, 5, COEF_MAX, 2048, COEF_MAX));
    write_reg(REG_VOICE1 + 1, pack_voice(0, WRAP_MAX, 0, COEF_MAX, 1));
    write_reg(REG_VOICE1 + 2, pack_voice(4, 4, COEF_MAX, COEF_MAX, 0));
    write_reg(REG_VOICE1 + 3, pack_voice(1, 2, COEF_MAX, COEF_MAX, 2048));
    write_reg(REG_VOICE1 + 4, pack_voice(WRAP_MAX, 0, 1, 1, 0));
    write_reg(REG_VOICE1 + 5, pack_voice(7, 7, 1, 1, COEF_MAX));
    write_reg(REG_MIX, ONE_Q12);
    write_reg(REG_SCALE, ONE_Q12);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    send_sample(SMP_MAX, SMP_MIN);
    send_sample(SMP_MIN, SMP_MAX);
    send_sample(0, 0);
    send_sample(-1, 1);
    repeat (6) send_sample(SMP_MAX, SMP_MAX);
    send_sample(SMP_MIN, SMP_MIN);
    send_sample(rand_sample(), rand_sample());
    drain();

    // Shrink a wrap below its head, swap frozen voices, levels above unity.
    write_reg(REG_VOICE1,     pack_voice(3, 5, COEF_MAX, 2048, 0));
    write_reg(REG_VOICE1 + 1, pack_voice(0, 2, 0, COEF_MAX, 1));
    write_reg(REG_VOICE1 + 2, pack_voice(4, 4, COEF_MAX, COEF_MAX, COEF_MAX));
    write_reg(REG_MIX, LEVEL_MAX);
    write_reg(REG_SCALE, LEVEL_MAX);
    repeat (4) send_sample(SMP_MAX, SMP_MIN);
    repeat (4) send_sample(SMP_MIN, SMP_MAX);
    drain();

    // Dry only.
    write_reg(REG_MIX, 0);
    write_reg(REG_SCALE, 0);
    send_sample(SMP_MAX, SMP_MIN);
    send_sample(SMP_MIN, SMP_MAX);
    send_sample(rand_sample(), rand_sample());
    drain();

    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct = (p < 3) ? 11 : (p < 6) ? 83 : 0;
      snk_idle_pct = (p < 3) ? 83 : (p < 6) ? 11 : 0;
      configure_random();
      if (p == 1 || p == 4 || p == 7) hold_out_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_sample(rand_sample(), rand_sample());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
